// File: hdl/tiaw_pkg.sv
// Shared types, codes and helpers for the typed integer ALU.
// Depends on nothing; every other file imports this package.
package tiaw_pkg;

    // Operation codes.
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_MUL  = 5'd2;
    localparam logic [4:0] OP_DIV  = 5'd3;
    localparam logic [4:0] OP_MOD  = 5'd4;
    localparam logic [4:0] OP_SHL  = 5'd5;
    localparam logic [4:0] OP_SHR  = 5'd6;
    localparam logic [4:0] OP_USHR = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_AND  = 5'd9;
    localparam logic [4:0] OP_XOR  = 5'd10;
    localparam logic [4:0] OP_GE   = 5'd11;
    localparam logic [4:0] OP_GT   = 5'd12;
    localparam logic [4:0] OP_LE   = 5'd13;
    localparam logic [4:0] OP_LT   = 5'd14;
    localparam logic [4:0] OP_EQ   = 5'd15;
    localparam logic [4:0] OP_NE   = 5'd16;
    localparam logic [4:0] OP_NEG  = 5'd17;
    localparam logic [4:0] OP_INV  = 5'd18;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_TYPE = 2'd3;

    // Width codes.
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    // One restoring division step per pipeline stage.
    localparam int DIV_STEPS = 64;

    // Decoded and promoted operands.
    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  lc;
        logic [1:0]  code;
        logic        sg;
        logic [1:0]  st;
        logic [63:0] a;
        logic [63:0] b;
    } dec_t;

    // Result context that travels to the end of the pipe.
    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  code;
        logic        sg;
        logic [1:0]  st;
        logic [63:0] res;
        logic        res_neg;
    } ctx_t;

    // Execute stage output: partial products and divider operands.
    typedef struct packed {
        ctx_t        ctx;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
        logic        ng;
        logic [63:0] ma;
        logic [63:0] mb;
    } exec_t;

    // Divider stage payload.
    typedef struct packed {
        ctx_t        ctx;
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] mb;
    } div_t;

    // All-ones mask of a width code.
    function automatic logic [63:0] wmask(input logic [1:0] code);
        logic [63:0] m;
        case (code)
            WC_8:    m = 64'h0000_0000_0000_00FF;
            WC_16:   m = 64'h0000_0000_0000_FFFF;
            WC_32:   m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Extend the low bits of a value from a width code, sign or zero.
    function automatic logic [63:0] extend(input logic [63:0] v, input logic [1:0] code,
                                           input logic sg);
        logic [63:0] r;
        case (code)
            WC_8:    r = {{56{sg & v[7]}}, v[7:0]};
            WC_16:   r = {{48{sg & v[15]}}, v[15:0]};
            WC_32:   r = {{32{sg & v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Signed minimum of a width, sign-extended to 64 bits.
    function automatic logic [63:0] smin(input logic [1:0] code);
        return ~(wmask(code) >> 1);
    endfunction

endpackage

// File: hdl/tiaw_decode.sv
// Decode stage: clamps width codes, extends operands and promotes the type.
// Depends on tiaw_pkg.
module tiaw_decode #(
    parameter int MAX_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [4:0]        op,
    input  logic [63:0]       left_value,
    input  logic [1:0]        left_width,
    input  logic              left_is_signed,
    input  logic [63:0]       right_value,
    input  logic [1:0]        right_width,
    input  logic              right_is_signed,
    output logic              dec_valid,
    output tiaw_pkg::dec_t    dec
);
    import tiaw_pkg::*;

    logic [1:0] lc;
    logic [1:0] rc;
    logic [1:0] mc;
    logic       promote;
    dec_t       dec_next;
    logic       valid_reg;
    dec_t       dec_reg;

    // Largest width code that does not exceed the widest supported type.
    function automatic logic [1:0] clamp(input logic [1:0] c);
        logic [1:0] k;
        k = c;
        for (int i = 0; i < 3; i++) begin
            if (k != 2'd0 && (8 << k) > MAX_WIDTH)
                k = k - 2'd1;
        end
        return k;
    endfunction

    // Promotion of the two operand types.
    always_comb
    begin
        lc = clamp(left_width);
        rc = clamp(right_width);
        mc = (lc > rc) ? lc : rc;
        promote = (op <= OP_MOD) || (op >= OP_OR && op <= OP_NE);
        dec_next.op   = op;
        dec_next.lc   = lc;
        dec_next.code = lc;
        dec_next.sg   = left_is_signed;
        dec_next.st   = ST_OK;
        dec_next.a    = extend(left_value, lc, left_is_signed);
        dec_next.b    = extend(right_value, rc, right_is_signed);
        if (promote) begin
            if (left_is_signed == right_is_signed) begin
                dec_next.code = mc;
            end
            else if ((8 << (int'(mc) + 1)) > MAX_WIDTH) begin
                dec_next.code = mc;
                dec_next.sg   = 1'b1;
                dec_next.st   = ST_TYPE;
            end
            else begin
                dec_next.code = mc + 2'd1;
                dec_next.sg   = 1'b1;
            end
        end
        else if (op == OP_NEG && !left_is_signed) begin
            // Unsigned negate widens to a signed type of twice the width.
            if ((8 << (int'(lc) + 1)) > MAX_WIDTH) begin
                dec_next.st = ST_OVF;
            end
            else begin
                dec_next.code = lc + 2'd1;
                dec_next.sg   = 1'b1;
            end
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

// File: hdl/tiaw_exec.sv
// Execute stage: simple operations, status checks, partial products, divider setup.
// Depends on tiaw_pkg.
module tiaw_exec (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             dec_valid,
    input  tiaw_pkg::dec_t   dec,
    output logic             ex_valid,
    output tiaw_pkg::exec_t  ex
);
    import tiaw_pkg::*;

    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic        an;
    logic        bn;
    logic        w64;
    logic [63:0] sum;
    logic [63:0] diff;
    logic        add_ovf;
    logic        sub_ovf;
    logic        b_big;
    logic [63:0] x;
    logic [63:0] fa;
    logic [63:0] fb;
    logic [63:0] ma;
    logic [63:0] mb;
    exec_t       ex_next;
    logic        valid_reg;
    exec_t       ex_reg;

    always_comb
    begin
        a    = dec.a;
        b    = dec.b;
        an   = a[63];
        bn   = b[63];
        m    = wmask(dec.code);
        w64  = (dec.code == WC_64);
        sum  = a + b;
        diff = a - b;

        // Overflow checks for add and subtract.
        if (dec.sg) begin
            add_ovf = w64 ? (an == bn && sum[63] != an) : (extend(sum, dec.code, 1'b1) != sum);
            sub_ovf = w64 ? (an != bn && diff[63] != an) : (extend(diff, dec.code, 1'b1) != diff);
        end
        else begin
            add_ovf = (sum < a) || (sum > m);
            sub_ovf = (a < b);
        end

        // Magnitudes for the multiplier and divider.
        ma = (dec.sg && an) ? (64'd0 - a) : a;
        mb = (dec.sg && bn) ? (64'd0 - b) : b;

        b_big = (b >= (64'd8 << dec.code));
        x     = a & m;
        fa    = dec.sg ? {~a[63], a[62:0]} : a;
        fb    = dec.sg ? {~b[63], b[62:0]} : b;

        ex_next.ctx.op      = dec.op;
        ex_next.ctx.code    = dec.code;
        ex_next.ctx.sg      = dec.sg;
        ex_next.ctx.st      = dec.st;
        ex_next.ctx.res     = 64'd0;
        ex_next.ctx.res_neg = 1'b0;
        ex_next.ll = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
        ex_next.lh = {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
        ex_next.hl = {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
        ex_next.hh = {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
        ex_next.ng = dec.sg & (an ^ bn);
        ex_next.ma = ma;
        ex_next.mb = mb;

        // Operation select; errors found at decode pass through untouched.
        if (dec.st == ST_OK) begin
            case (dec.op)
                OP_ADD:
                begin
                    ex_next.ctx.res = sum;
                    if (add_ovf)
                        ex_next.ctx.st = ST_OVF;
                end
                OP_SUB:
                begin
                    ex_next.ctx.res = diff;
                    if (sub_ovf)
                        ex_next.ctx.st = ST_OVF;
                end
                OP_DIV, OP_MOD:
                begin
                    if (b == 64'd0)
                        ex_next.ctx.st = ST_DIVZ;
                    else if (dec.sg && a == smin(dec.code) && b == '1)
                        ex_next.ctx.st = ST_OVF;
                    else if (dec.op == OP_DIV)
                        ex_next.ctx.res_neg = dec.sg & (an ^ bn);
                    else
                        ex_next.ctx.res_neg = dec.sg & an;
                end
                OP_SHL:  ex_next.ctx.res = b_big ? 64'd0 : (x << b[5:0]);
                OP_USHR: ex_next.ctx.res = b_big ? 64'd0 : (x >> b[5:0]);
                OP_SHR:
                begin
                    if (dec.sg) begin
                        if (b_big)
                            ex_next.ctx.res = {64{an}};
                        else if (an)
                            ex_next.ctx.res = ~((~a) >> b[5:0]);
                        else
                            ex_next.ctx.res = a >> b[5:0];
                    end
                    else begin
                        ex_next.ctx.res = b_big ? 64'd0 : (x >> b[5:0]);
                    end
                end
                OP_OR:  ex_next.ctx.res = a | b;
                OP_AND: ex_next.ctx.res = a & b;
                OP_XOR: ex_next.ctx.res = a ^ b;
                OP_GE:  ex_next.ctx.res = {63'd0, fa >= fb};
                OP_GT:  ex_next.ctx.res = {63'd0, fa > fb};
                OP_LE:  ex_next.ctx.res = {63'd0, fa <= fb};
                OP_LT:  ex_next.ctx.res = {63'd0, fa < fb};
                OP_EQ:  ex_next.ctx.res = {63'd0, a == b};
                OP_NE:  ex_next.ctx.res = {63'd0, a != b};
                OP_NEG:
                begin
                    // A signed minimum has no positive counterpart.
                    if (dec.sg && dec.code == dec.lc && a == smin(dec.lc))
                        ex_next.ctx.st = ST_OVF;
                    else
                        ex_next.ctx.res = 64'd0 - a;
                end
                OP_INV: ex_next.ctx.res = ~a;
                default: ex_next.ctx.res = 64'd0;
            endcase
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ex_reg <= ex_next;
    end

    assign ex_valid = valid_reg;
    assign ex       = ex_reg;

endmodule

// File: hdl/tiaw_mulsum.sv
// Multiply finish stage: sums partial products, checks the range, loads the divider.
// Depends on tiaw_pkg.
module tiaw_mulsum (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             ex_valid,
    input  tiaw_pkg::exec_t  ex,
    output logic             ms_valid,
    output tiaw_pkg::div_t   ms
);
    import tiaw_pkg::*;

    logic [63:0] mid;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] m;
    logic [63:0] limit;
    div_t        ms_next;
    logic        valid_reg;
    div_t        ms_reg;

    always_comb
    begin
        mid = {32'd0, ex.ll[63:32]} + {32'd0, ex.lh[31:0]} + {32'd0, ex.hl[31:0]};
        lo  = {mid[31:0], ex.ll[31:0]};
        hi  = ex.hh + {32'd0, ex.lh[63:32]} + {32'd0, ex.hl[63:32]} + {32'd0, mid[63:32]};
        m   = wmask(ex.ctx.code);

        // A negative product may reach one past the positive maximum.
        if (ex.ctx.sg)
            limit = ex.ng ? ((m >> 1) + 64'd1) : (m >> 1);
        else
            limit = m;

        ms_next.ctx = ex.ctx;
        ms_next.rem = 64'd0;
        ms_next.dq  = ex.ma;
        ms_next.mb  = ex.mb;
        if (ex.ctx.op == OP_MUL && ex.ctx.st == ST_OK) begin
            if (hi != 64'd0 || lo > limit) begin
                ms_next.ctx.st = ST_OVF;
            end
            else begin
                ms_next.ctx.res     = lo;
                ms_next.ctx.res_neg = ex.ng;
            end
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ex_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ms_reg <= ms_next;
    end

    assign ms_valid = valid_reg;
    assign ms       = ms_reg;

endmodule

// File: hdl/tiaw_div_step.sv
// One restoring division step: brings down one dividend bit, yields one quotient bit.
// Depends on tiaw_pkg.
module tiaw_div_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  tiaw_pkg::div_t  din,
    output logic            out_valid,
    output tiaw_pkg::div_t  dout
);
    import tiaw_pkg::*;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        fits;
    div_t        d_next;
    logic        valid_reg;
    div_t        d_reg;

    // Trial subtract of the divisor from the partial remainder.
    always_comb
    begin
        trial  = {din.rem, din.dq[63]};
        diff   = trial - {1'b0, din.mb};
        fits   = !diff[64];
        d_next = din;
        d_next.rem = fits ? diff[63:0] : trial[63:0];
        d_next.dq  = {din.dq[62:0], fits};
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign out_valid = valid_reg;
    assign dout      = d_reg;

endmodule

// File: hdl/typed_integer_alu_with_overflow.sv
// Top level of the typed integer ALU: pipeline stages and the output register.
// Depends on tiaw_pkg, tiaw_decode, tiaw_exec, tiaw_mulsum and tiaw_div_step.

// Typed integer ALU with overflow, divide-by-zero and type-error status. It takes
// one beat per cycle and returns each result once it has passed every register of the pipe
// (decode, execute, multiply finish, 64 division steps, output register). Every
// operation runs the full length of the pipe, which is set by the 64-bit divider
// that resolves one quotient bit per stage; results leave in order. When the
// output beat is not taken, the whole pipe holds and the input is not ready.
module typed_integer_alu_with_overflow #(
    parameter int MAX_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  op,
    input  logic [63:0] left_value,
    input  logic [1:0]  left_width,
    input  logic        left_is_signed,
    input  logic [63:0] right_value,
    input  logic [1:0]  right_width,
    input  logic        right_is_signed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_value,
    output logic [1:0]  result_width,
    output logic        result_is_signed,
    output logic [1:0]  status
);
    import tiaw_pkg::*;

    logic        en;
    logic        dec_valid;
    dec_t        dec;
    logic        ex_valid;
    exec_t       ex;
    logic        ms_valid;
    div_t        ms;
    logic        dv_valid [DIV_STEPS+1];
    div_t        dv       [DIV_STEPS+1];
    div_t        last;
    logic [63:0] sel;
    logic [63:0] val;
    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  width_reg;
    logic        signed_reg;
    logic [1:0]  status_reg;

    // The pipe advances whenever the output register is free or being drained.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    tiaw_decode #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_valid),
        .op              (op),
        .left_value      (left_value),
        .left_width      (left_width),
        .left_is_signed  (left_is_signed),
        .right_value     (right_value),
        .right_width     (right_width),
        .right_is_signed (right_is_signed),
        .dec_valid       (dec_valid),
        .dec             (dec)
    );

    tiaw_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .dec_valid (dec_valid),
        .dec       (dec),
        .ex_valid  (ex_valid),
        .ex        (ex)
    );

    tiaw_mulsum u_mulsum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ex_valid (ex_valid),
        .ex       (ex),
        .ms_valid (ms_valid),
        .ms       (ms)
    );

    assign dv_valid[0] = ms_valid;
    assign dv[0]       = ms;

    // Division chain, one quotient bit per stage.
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        tiaw_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[i]),
            .din       (dv[i]),
            .out_valid (dv_valid[i+1]),
            .dout      (dv[i+1])
        );
    end

    // Final select, sign fix and masking to the result width.
    always_comb
    begin
        last = dv[DIV_STEPS];
        case (last.ctx.op)
            OP_DIV:  sel = last.dq;
            OP_MOD:  sel = last.rem;
            default: sel = last.ctx.res;
        endcase
        val = last.ctx.res_neg ? (64'd0 - sel) : sel;
        if (last.ctx.st != ST_OK)
            val = 64'd0;
        val = val & wmask(last.ctx.code);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            value_reg  <= val;
            width_reg  <= last.ctx.code;
            signed_reg <= last.ctx.sg;
            status_reg <= last.ctx.st;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_value     = value_reg;
    assign result_width     = width_reg;
    assign result_is_signed = signed_reg;
    assign status           = status_reg;

endmodule
